// ===== rtl/core/crd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crd_pkg;

  localparam int COMP_BITS  = 21;   // Q8.12 vector component
  localparam int NORM_BITS  = 30;   // normalized magnitude, top bit at NORM_BITS-1
  localparam int ROOT_BITS  = 31;   // floor(sqrt) of the square sum
  localparam int SUM_BITS   = 2 * ROOT_BITS;
  localparam int FRAC_BITS  = 16;   // Q1.16 output fraction
  localparam int Q_BITS     = FRAC_BITS + 1;
  localparam int OUT_BITS   = FRAC_BITS + 2;
  localparam int REG_BITS   = 3 * COMP_BITS;
  localparam int IDX_BITS   = 2;

  localparam logic [IDX_BITS-1:0] REG_BASE     = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_COL_STEP = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_ROW_STEP = 2'd2;

  localparam logic [Q_BITS-1:0] UNIT_Q16 = Q_BITS'(1) << FRAC_BITS;

  typedef logic signed [COMP_BITS-1:0] comp_t;
  typedef logic [NORM_BITS-1:0]        nmag_t;
  typedef logic signed [OUT_BITS-1:0]  dir_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
  } sign_info_t;

  function automatic comp_t comp_of(input logic [REG_BITS-1:0] r, input int k);
    comp_t c;
    c = r[k*COMP_BITS +: COMP_BITS];
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crd_dir.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_dir #(
  parameter int COORD_BITS = 12,
  parameter int DW         = COORD_BITS + 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [COORD_BITS-1:0]         pixel_column,
  input  logic [COORD_BITS-1:0]         pixel_row,
  input  logic [crd_pkg::REG_BITS-1:0]  base_direction,
  input  logic [crd_pkg::REG_BITS-1:0]  column_step,
  input  logic [crd_pkg::REG_BITS-1:0]  row_step,
  output logic                          out_valid,
  output logic [DW-1:0]                 mag [3],
  output logic [2:0]                    neg
);

  localparam int PW = COORD_BITS + 1 + crd_pkg::COMP_BITS;

  logic signed [PW-1:0] prod_c [3];
  logic signed [PW-1:0] prod_r [3];
  crd_pkg::comp_t       base_q [3];
  logic signed [DW-1:0] d      [3];
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // products per component, then the exact sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_c[k] <= PW'($signed({1'b0, pixel_column}))
                   * PW'(crd_pkg::comp_of(column_step, k));
        prod_r[k] <= PW'($signed({1'b0, pixel_row}))
                   * PW'(crd_pkg::comp_of(row_step, k));
        base_q[k] <= crd_pkg::comp_of(base_direction, k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = DW'(base_q[k]) + DW'(prod_c[k]) + DW'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] <= d[k][DW-1];
        mag[k] <= d[k][DW-1] ? DW'(-d[k]) : DW'(d[k]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crd_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_norm #(
  parameter int DW = 36
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [DW-1:0]                 mag_in [3],
  input  logic [2:0]                    neg_in,
  output logic                          out_valid,
  output logic [crd_pkg::SUM_BITS-1:0]  sq_sum,
  output crd_pkg::nmag_t                nmag [3],
  output crd_pkg::sign_info_t           info
);

  localparam int PSW = $clog2(DW);
  localparam int NB  = crd_pkg::NORM_BITS;
  localparam int SQW = 2 * NB;

  logic [4:0]          vld;
  logic [DW-1:0]       mag1 [3];
  logic [DW-1:0]       mag2 [3];
  logic [DW-1:0]       mx1;
  logic [DW-1:0]       mx;
  logic [PSW-1:0]      pos;
  logic [PSW-1:0]      pos2;
  logic                rsh;
  logic [PSW-1:0]      amt;
  crd_pkg::sign_info_t info1, info2, info3, info4;
  crd_pkg::nmag_t      nm3 [3];
  crd_pkg::nmag_t      nm4 [3];
  logic [SQW-1:0]      sq4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end
  assign out_valid = vld[4];

  always_comb begin
    mx = mag_in[0];
    if (mag_in[1] > mx) mx = mag_in[1];
    if (mag_in[2] > mx) mx = mag_in[2];
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx1[i]) pos = PSW'(i);
    end
  end

  assign rsh = pos2 >= PSW'(NB - 1);
  assign amt = rsh ? PSW'(pos2 - PSW'(NB - 1)) : PSW'(PSW'(NB - 1) - pos2);

  always_ff @(posedge clk) begin
    if (en) begin
      // largest magnitude
      mag1  <= mag_in;
      mx1   <= mx;
      info1 <= '{neg: neg_in, degenerate: (mx == '0)};
      // leading one
      mag2  <= mag1;
      pos2  <= pos;
      info2 <= info1;
      // common shift; right shifts truncate
      for (int k = 0; k < 3; k++) begin
        nm3[k] <= rsh ? NB'(mag2[k] >> amt) : NB'(mag2[k] << amt);
      end
      info3 <= info2;
      // squares
      for (int k = 0; k < 3; k++) begin
        sq4[k] <= SQW'(nm3[k]) * SQW'(nm3[k]);
      end
      nm4   <= nm3;
      info4 <= info3;
      // square sum
      sq_sum <= crd_pkg::SUM_BITS'(sq4[0]) + crd_pkg::SUM_BITS'(sq4[1])
              + crd_pkg::SUM_BITS'(sq4[2]);
      nmag   <= nm4;
      info   <= info4;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crd_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [crd_pkg::SUM_BITS-1:0]  sq_sum,
  input  crd_pkg::nmag_t                nmag_in [3],
  input  crd_pkg::sign_info_t           info_in,
  output logic                          out_valid,
  output logic [crd_pkg::ROOT_BITS-1:0] root,
  output crd_pkg::nmag_t                nmag [3],
  output crd_pkg::sign_info_t           info
);

  localparam int RB = crd_pkg::ROOT_BITS;
  localparam int SB = crd_pkg::SUM_BITS;
  localparam int TW = SB + 2;

  logic [SB-1:0]       rem_s  [RB+1];
  logic [RB-1:0]       root_s [RB+1];
  crd_pkg::nmag_t      mag_s  [RB+1][3];
  crd_pkg::sign_info_t info_s [RB+1];
  logic                vld_s  [RB+1];

  assign rem_s[0]  = sq_sum;
  assign root_s[0] = '0;
  assign mag_s[0]  = nmag_in;
  assign info_s[0] = info_in;
  assign vld_s[0]  = in_valid;

  // one result bit per stage, most significant first
  for (genvar i = 0; i < RB; i++) begin : g_bit
    localparam int B = RB - 1 - i;
    logic [TW-1:0] trial;
    logic          take;

    assign trial = (TW'(root_s[i]) << (B + 1)) | (TW'(1) << (2 * B));
    assign take  = TW'(rem_s[i]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= take ? SB'(TW'(rem_s[i]) - trial) : rem_s[i];
        root_s[i+1] <= take ? (root_s[i] | (RB'(1) << B)) : root_s[i];
        mag_s[i+1]  <= mag_s[i];
        info_s[i+1] <= info_s[i];
      end
    end
  end

  assign out_valid = vld_s[RB];
  assign root      = root_s[RB];
  assign nmag      = mag_s[RB];
  assign info      = info_s[RB];

endmodule
`default_nettype wire

// ===== rtl/core/crd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [crd_pkg::ROOT_BITS-1:0] root,
  input  crd_pkg::nmag_t                nmag [3],
  input  crd_pkg::sign_info_t           info_in,
  output logic                          out_valid,
  output crd_pkg::dir_t                 dir [3],
  output logic                          degenerate
);

  localparam int RB  = crd_pkg::ROOT_BITS;
  localparam int QB  = crd_pkg::Q_BITS;
  localparam int NW  = crd_pkg::NORM_BITS + crd_pkg::FRAC_BITS + 1;
  localparam int DVW = RB + QB;

  logic [NW-1:0]       rem_s  [QB+1][3];
  logic [QB-1:0]       quo_s  [QB+1][3];
  logic [RB-1:0]       dv_s   [QB+1];
  crd_pkg::sign_info_t info_s [QB+1];
  logic                vld_s  [QB+1];
  logic [QB-1:0]       qc     [3];

  // numerator with rounding term
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem_s[0][k] <= (NW'(nmag[k]) << crd_pkg::FRAC_BITS) + NW'(root >> 1);
        quo_s[0][k] <= '0;
      end
      dv_s[0]   <= root;
      info_s[0] <= info_in;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_qbit
    localparam int B = QB - 1 - j;
    logic [DVW-1:0] dsh;

    assign dsh = DVW'(dv_s[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[j+1] <= 1'b0;
      end else if (en) begin
        vld_s[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (DVW'(rem_s[j][k]) >= dsh) begin
            rem_s[j+1][k] <= NW'(DVW'(rem_s[j][k]) - dsh);
            quo_s[j+1][k] <= quo_s[j][k] | (QB'(1) << B);
          end else begin
            rem_s[j+1][k] <= rem_s[j][k];
            quo_s[j+1][k] <= quo_s[j][k];
          end
        end
        dv_s[j+1]   <= dv_s[j];
        info_s[j+1] <= info_s[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (quo_s[QB][k] > crd_pkg::UNIT_Q16) ? crd_pkg::UNIT_Q16 : quo_s[QB][k];
    end
  end

  // sign, zero vector and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_s[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (info_s[QB].degenerate) begin
          dir[k] <= '0;
        end else if (info_s[QB].neg[k]) begin
          dir[k] <= -$signed({1'b0, qc[k]});
        end else begin
          dir[k] <= $signed({1'b0, qc[k]});
        end
      end
      degenerate <= info_s[QB].degenerate;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/camera_ray_direction_gen_top.sv =====
// Pinhole camera primary-ray direction generator.
// Input stream: one beat per pixel, s_tdata carries the column and row index.
// Output stream: one beat per input beat, in order, with the unit-length ray
// direction as three signed Q1.16 components and a degenerate flag in m_tuser
// (set when the unnormalized direction is zero; the components are then zero).
// Direction before normalization is base + column * column_step + row * row_step,
// each register packing x, y, z as signed Q8.12 in 21-bit slices.
// Configuration: write cfg_wdata into register cfg_index (0 base, 1 column step,
// 2 row step) while cfg_we is high; write only while the pipeline is empty.
// From input beat to output beat, a beat passes the products and sum, then
// normalize and square sum, then the bit-per-stage square root, then the three
// parallel bit-per-stage dividers plus sign and output register.
// Throughput is one beat per cycle while the receiver does not stall.
// Reset clears all valid bits and the three registers; no clearing pass.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module camera_ray_direction_gen_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [COORD_BITS-1:0] pixel_column, [2*COORD_BITS-1:COORD_BITS] pixel_row
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [17:0] direction_x, [35:18] direction_y, [53:36] direction_z, [55:54] zero
  output logic [55:0]                        m_tdata,
  // [0] degenerate
  output logic                               m_tuser,
  input  logic                               cfg_we,
  input  logic [crd_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [crd_pkg::REG_BITS-1:0]       cfg_wdata
);

  localparam int DW = COORD_BITS + 24;

  logic [crd_pkg::REG_BITS-1:0]  base_direction;
  logic [crd_pkg::REG_BITS-1:0]  column_step;
  logic [crd_pkg::REG_BITS-1:0]  row_step;
  logic                          en;

  logic                          dir_valid;
  logic [DW-1:0]                 dir_mag [3];
  logic [2:0]                    dir_neg;
  logic                          norm_valid;
  logic [crd_pkg::SUM_BITS-1:0]  norm_sum;
  crd_pkg::nmag_t                norm_mag [3];
  crd_pkg::sign_info_t           norm_info;
  logic                          sqrt_valid;
  logic [crd_pkg::ROOT_BITS-1:0] sqrt_root;
  crd_pkg::nmag_t                sqrt_mag [3];
  crd_pkg::sign_info_t           sqrt_info;
  crd_pkg::dir_t                 dir_out [3];
  logic                          degenerate;

  // Configuration registers; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_direction <= '0;
      column_step    <= '0;
      row_step       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crd_pkg::REG_BASE:     base_direction <= cfg_wdata;
        crd_pkg::REG_COL_STEP: column_step    <= cfg_wdata;
        crd_pkg::REG_ROW_STEP: row_step       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance every stage unless a finished beat waits at the output.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  crd_dir #(.COORD_BITS(COORD_BITS), .DW(DW)) u_dir (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_tvalid),
    .pixel_column   (s_tdata[COORD_BITS-1:0]),
    .pixel_row      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .base_direction (base_direction),
    .column_step    (column_step),
    .row_step       (row_step),
    .out_valid      (dir_valid),
    .mag            (dir_mag),
    .neg            (dir_neg)
  );

  crd_norm #(.DW(DW)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dir_valid),
    .mag_in    (dir_mag),
    .neg_in    (dir_neg),
    .out_valid (norm_valid),
    .sq_sum    (norm_sum),
    .nmag      (norm_mag),
    .info      (norm_info)
  );

  crd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .sq_sum    (norm_sum),
    .nmag_in   (norm_mag),
    .info_in   (norm_info),
    .out_valid (sqrt_valid),
    .root      (sqrt_root),
    .nmag      (sqrt_mag),
    .info      (sqrt_info)
  );

  crd_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sqrt_valid),
    .root       (sqrt_root),
    .nmag       (sqrt_mag),
    .info_in    (sqrt_info),
    .out_valid  (m_tvalid),
    .dir        (dir_out),
    .degenerate (degenerate)
  );

  assign m_tdata = {2'b00, dir_out[2], dir_out[1], dir_out[0]};
  assign m_tuser = degenerate;

  // A degenerate beat carries zero components.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[53:0] == '0)
    else $error("degenerate beat with nonzero direction");

  // Components stay within the unit range.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[17:0]) <= 18'sd65536
              && $signed(m_tdata[17:0]) >= -18'sd65536
              && $signed(m_tdata[35:18]) <= 18'sd65536
              && $signed(m_tdata[35:18]) >= -18'sd65536
              && $signed(m_tdata[53:36]) <= 18'sd65536
              && $signed(m_tdata[53:36]) >= -18'sd65536)
    else $error("direction component outside unit range");

  // No output beat right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
